FILE: sv/ctfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctfq_pkg
// Types shared by the CAN transmit frame queue: transaction payloads, the
// stored frame and the per-cell control word.
// ----------------------------------------------------------------------------
package ctfq_pkg;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POLL = 1'b1
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [10:0] frame_id;
		logic [3:0]  frame_length;
		logic [63:0] payload;
		logic        transmitter_free;
	} ctfq_req_t;

	typedef struct packed {
		logic        sent;
		logic [10:0] sent_id;
		logic [3:0]  sent_length;
		logic [63:0] sent_payload;
		logic        overwrote;
		logic [3:0]  occupancy;
	} ctfq_rsp_t;

	// one stored frame: 11 + 4 + 64 = 79 bits
	typedef struct packed {
		logic [10:0] id;
		logic [3:0]  length;
		logic [63:0] payload;
	} frame_t;

	// per-cell control
	typedef struct packed {
		logic load;   // take the incoming frame
		logic shift;  // take the neighbor's frame (queue pops)
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: sv/ctfq_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctfq_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ctfq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/ctfq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctfq_cell
// One slot of the shifting frame chain; loads a new frame or takes its
// upstream neighbor's frame when the queue pops.
// ----------------------------------------------------------------------------
module ctfq_cell
	import ctfq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire frame_t    din,
	input  wire frame_t    nbr,
	output frame_t         q
);

	frame_t slot_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_q <= din;
		end else if (ctl.shift) begin
			slot_q <= nbr;
		end
	end

	assign q = slot_q;

endmodule
`default_nettype wire

FILE: sv/can_tx_frame_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_tx_frame_queue
// Transmit queue of CAN frames in front of a single controller transmit
// buffer, built as a row of shifting frame cells with the head at cell 0.
// ----------------------------------------------------------------------------
// Result: registered, and shown the cycle after the request is accepted.
// Throughput: one transaction per cycle while the sink takes each result;
//   a held result stalls req.ready. The pointer update, the write into
//   the cell row and the head read all complete in the accepting cycle.
// Reset: arst_n clears head, tail and the result-valid flag; frame cells are
//   not cleared and only ever read after being written.
// ----------------------------------------------------------------------------
module can_tx_frame_queue
	import ctfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ctfq_stream_if.sink   req,
	ctfq_stream_if.source rsp
);

	localparam int IW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OW = (IW > 4) ? IW : 4;
	localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);

	// Absolute head/tail pointers; cell k of the row holds slot head+k.
	logic [IW-1:0] head_q, tail_q;
	logic          rsp_valid_q;
	ctfq_rsp_t     rsp_q;

	frame_t        cells [QUEUE_DEPTH];
	frame_t        new_frame;
	cell_ctl_t     ctl   [QUEUE_DEPTH];

	logic          accept;
	logic          push, pop, overwrite, store;
	logic [IW-1:0] count;       // tail - head before the transaction
	logic [IW-1:0] tail_push;   // tail after the push
	logic [IW-1:0] head_inc;
	logic [IW-1:0] head_nxt, tail_nxt;
	logic [IW-1:0] wpos;        // cell taking the new frame after any shift
	logic [OW-1:0] occ_wide;
	frame_t        head_frame;
	ctfq_rsp_t     rsp_nxt;

	// Output register frees up whenever the sink takes its transaction.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign new_frame.id      = req.data.frame_id;
	assign new_frame.length  = req.data.frame_length;
	assign new_frame.payload = req.data.payload;

	// Pointer arithmetic. Tail holds at the last slot once it gets there.
	always_comb begin
		push      = (req.data.action == ACT_PUSH);
		count     = tail_q - head_q;
		overwrite = push && (tail_q == LAST);
		tail_push = (push && !overwrite) ? tail_q + 1'b1 : tail_q;
		pop       = (head_q != tail_push) && req.data.transmitter_free;
		head_inc  = head_q + 1'b1;
		head_nxt  = head_q;
		tail_nxt  = tail_push;
		if (pop) begin
			if (head_inc == tail_push) begin
				// emptied: both pointers return to zero
				head_nxt = '0;
				tail_nxt = '0;
			end else begin
				head_nxt = head_inc;
			end
		end
		// A push into an empty queue that pops at once bypasses the row.
		store = push && !(pop && (count == '0));
		wpos  = pop ? count - 1'b1 : count;
	end

	// Head frame, with bypass for a frame pushed into an empty queue.
	assign head_frame = (push && (count == '0)) ? new_frame : cells[0];

	// The cell row.
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		frame_t nbr;
		if (k == QUEUE_DEPTH - 1) begin : g_end
			assign nbr = cells[k];
		end else begin : g_mid
			assign nbr = cells[k+1];
		end

		assign ctl[k].load  = accept && store && (wpos == IW'(k));
		assign ctl[k].shift = accept && pop;

		ctfq_cell u_cell (
			.clk (clk),
			.ctl (ctl[k]),
			.din (new_frame),
			.nbr (nbr),
			.q   (cells[k])
		);
	end

	// Result of the transaction.
	always_comb begin
		occ_wide              = OW'(tail_nxt - head_nxt);
		rsp_nxt.sent          = pop;
		rsp_nxt.sent_id       = pop ? head_frame.id      : '0;
		rsp_nxt.sent_length   = pop ? head_frame.length  : '0;
		rsp_nxt.sent_payload  = pop ? head_frame.payload : '0;
		rsp_nxt.overwrote     = overwrite;
		rsp_nxt.occupancy     = occ_wide[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q <= head_nxt;
				tail_q <= tail_nxt;
			end
			if (req.ready) begin
				rsp_valid_q <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule
`default_nettype wire

FILE: tb/can_tx_frame_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_tx_frame_queue_tb
// Self-checking bench for the CAN transmit frame queue. Request transactions
// are fed through a scoreboard that keeps its own copy of the slots and the
// head/tail pointers and predicts each response, which is then compared field
// by field. Both channels stall at random, and one long response hold-off
// backs the queue up into its request port.
// ----------------------------------------------------------------------------
module can_tx_frame_queue_tb;
	import ctfq_pkg::*;

	localparam int          DEPTH       = 16;
	localparam int          ITEM_TARGET = 650;  // total request transactions
	localparam int          QUIET_TAIL  = 80;   // last stretch runs with no idling
	localparam int          LONG_STALL  = 300;  // response hold-off, in cycles
	localparam int unsigned CYCLE_LIMIT = 200000;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the queue and holds the responses still owed.
	// ------------------------------------------------------------------------
	class frame_queue_scoreboard;
		frame_t      slots[DEPTH];
		int unsigned head;
		int unsigned tail;
		ctfq_rsp_t   owed_q[$];
		int          errors;

		function new();
			head   = 0;
			tail   = 0;
			errors = 0;
		endfunction

		// predict the response of one accepted request
		function void note_request(ctfq_req_t r);
			ctfq_rsp_t e;
			e = '0;
			if (tail >= DEPTH) tail = DEPTH - 1;
			if (head > tail) head = tail;
			if (r.action == ACT_PUSH) begin
				// tail parked on the last slot: the push replaces that frame
				e.overwrote = (tail == DEPTH - 1);
				slots[tail].id      = r.frame_id;
				slots[tail].length  = r.frame_length;
				slots[tail].payload = r.payload;
				tail++;
				if (tail >= DEPTH) tail = DEPTH - 1;
			end
			if (head != tail && r.transmitter_free) begin
				e.sent         = 1'b1;
				e.sent_id      = slots[head].id;
				e.sent_length  = slots[head].length;
				e.sent_payload = slots[head].payload;
				head++;
				if (head == tail) begin
					head = 0;
					tail = 0;
				end
			end
			e.occupancy = 4'(tail - head);
			owed_q.push_back(e);
		endfunction

		function void check_response(ctfq_rsp_t got);
			ctfq_rsp_t e;
			if (owed_q.size() == 0) begin
				$error("response with no request outstanding: %h", got);
				errors++;
				return;
			end
			e = owed_q.pop_front();
			if (got.sent !== e.sent) begin
				$error("sent: expected %0d, got %0d", e.sent, got.sent);
				errors++;
			end
			if (got.sent_id !== e.sent_id) begin
				$error("sent_id: expected %h, got %h", e.sent_id, got.sent_id);
				errors++;
			end
			if (got.sent_length !== e.sent_length) begin
				$error("sent_length: expected %h, got %h", e.sent_length, got.sent_length);
				errors++;
			end
			if (got.sent_payload !== e.sent_payload) begin
				$error("sent_payload: expected %h, got %h", e.sent_payload, got.sent_payload);
				errors++;
			end
			if (got.overwrote !== e.overwrote) begin
				$error("overwrote: expected %0d, got %0d", e.overwrote, got.overwrote);
				errors++;
			end
			if (got.occupancy !== e.occupancy) begin
				$error("occupancy: expected %0d, got %0d", e.occupancy, got.occupancy);
				errors++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	bit                    req_fire;       // request accepted at the last rising edge
	bit                    quiet;          // final stretch: no idling on either side
	bit                    stall_pending;  // ask the receiver for one long hold-off
	int unsigned           cycle_count;
	frame_queue_scoreboard sb;

	ctfq_stream_if #(.T(ctfq_req_t)) req_if ();
	ctfq_stream_if #(.T(ctfq_rsp_t)) rsp_if ();

	can_tx_frame_queue #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge. The sender only looks
	// at req_fire on the falling edge, so it never races the block.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
		req_fire <= arst_n && req_if.valid && req_if.ready;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
			if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: ready toggles in bursts; one long hold-off on request so the
	// result register stays full and the queue stops taking requests.
	// ------------------------------------------------------------------------
	initial begin
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (stall_pending) begin
				rsp_if.ready = 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				stall_pending = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_if.ready = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				rsp_if.ready = 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender helpers. Each is entered on a falling edge and leaves on one.
	// ------------------------------------------------------------------------
	function automatic bit chance(int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic ctfq_req_t make_item(action_t act, bit tx_free);
		ctfq_req_t r;
		r.action           = act;
		r.frame_id         = 11'($urandom_range(0, 2047));
		r.frame_length     = 4'($urandom_range(0, 15));
		r.payload          = {$urandom, $urandom};
		r.transmitter_free = tx_free;
		return r;
	endfunction

	// hold the transaction on the channel until the block takes it
	task automatic offer(ctfq_req_t item);
		req_if.data  = item;
		req_if.valid = 1'b1;
		do @(negedge clk); while (!req_fire);
	endtask

	task automatic offer_frame(action_t act, logic [10:0] id, logic [3:0] len,
			logic [63:0] pay, bit tx_free);
		ctfq_req_t r;
		r.action           = act;
		r.frame_id         = id;
		r.frame_length     = len;
		r.payload          = pay;
		r.transmitter_free = tx_free;
		offer(r);
	endtask

	task automatic sender_gap();
		req_if.valid = 1'b0;
		repeat ($urandom_range(1, 15)) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int          issued;
		int          seg;
		int          seg_len;
		int unsigned push_pct;
		int unsigned free_pct;
		bit          calm;

		sb            = new();
		issued        = 0;
		quiet         = 1'b0;
		stall_pending = 1'b0;
		cycle_count   = 0;
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.data   = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed ---
		// push into an empty queue with the transmitter free: out at once
		offer_frame(ACT_PUSH, 11'h000, 4'h0, 64'h0, 1'b1);
		offer_frame(ACT_PUSH, 11'h7FF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		// polls on an empty queue, free and busy
		offer_frame(ACT_POLL, 11'h7FF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		offer_frame(ACT_POLL, 11'h000, 4'h0, 64'h0, 1'b0);
		// transmitter busy: fill to the parked tail, then overwrite twice
		for (int k = 0; k < DEPTH + 1; k++) begin
			offer(make_item(ACT_PUSH, 1'b0));
			issued++;
		end
		offer_frame(ACT_POLL, 11'h555, 4'h8, 64'h0123_4567_89AB_CDEF, 1'b0);
		// overwrite on a full queue while the head goes out
		offer_frame(ACT_PUSH, 11'h2AA, 4'h9, 64'hA5A5_5A5A_F00F_0FF0, 1'b1);
		offer_frame(ACT_POLL, 11'h000, 4'h0, 64'h0, 1'b1);
		issued += 7;

		// --- random: fill, drain and mixed segments ---
		stall_pending = 1'b1;
		while (issued < ITEM_TARGET) begin
			seg     = $urandom_range(0, 9);
			seg_len = $urandom_range(4, 20);
			calm    = chance(25);
			if (seg < 4) begin
				push_pct = 90;  // back the queue up to full and past it
				free_pct = 15;
			end else if (seg < 7) begin
				push_pct = 20;  // drain
				free_pct = 85;
			end else begin
				push_pct = 50;
				free_pct = 50;
			end
			for (int k = 0; k < seg_len && issued < ITEM_TARGET; k++) begin
				if (issued >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
				if (!calm && !quiet && chance(12)) sender_gap();
				offer(make_item(chance(push_pct) ? ACT_PUSH : ACT_POLL, chance(free_pct)));
				issued++;
			end
		end
		req_if.valid = 1'b0;

		// drain outstanding responses, then wait for stray output
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
